[src/armu_pkg.sv]
// shared types and request codes for the atomic read-modify-write memory unit
package armu_pkg;

  localparam int REQ_W  = 5;
  localparam int SIZE_W = 2;
  localparam int ADDR_W = 11;
  localparam int DATA_W = 64;

  localparam logic [REQ_W-1:0] REQ_LOAD       = 5'd0;
  localparam logic [REQ_W-1:0] REQ_STORE      = 5'd1;
  localparam logic [REQ_W-1:0] REQ_XCHG       = 5'd2;
  localparam logic [REQ_W-1:0] REQ_CAS        = 5'd3;
  localparam logic [REQ_W-1:0] REQ_FETCH_ADD  = 5'd4;
  localparam logic [REQ_W-1:0] REQ_FETCH_SUB  = 5'd5;
  localparam logic [REQ_W-1:0] REQ_FETCH_AND  = 5'd6;
  localparam logic [REQ_W-1:0] REQ_FETCH_OR   = 5'd7;
  localparam logic [REQ_W-1:0] REQ_FETCH_XOR  = 5'd8;
  localparam logic [REQ_W-1:0] REQ_FETCH_NAND = 5'd9;
  localparam logic [REQ_W-1:0] REQ_ADD_FETCH  = 5'd10;
  localparam logic [REQ_W-1:0] REQ_SUB_FETCH  = 5'd11;
  localparam logic [REQ_W-1:0] REQ_AND_FETCH  = 5'd12;
  localparam logic [REQ_W-1:0] REQ_OR_FETCH   = 5'd13;
  localparam logic [REQ_W-1:0] REQ_XOR_FETCH  = 5'd14;
  localparam logic [REQ_W-1:0] REQ_NAND_FETCH = 5'd15;
  localparam logic [REQ_W-1:0] REQ_FLAG_SET   = 5'd16;
  localparam logic [REQ_W-1:0] REQ_FLAG_CLEAR = 5'd17;

  localparam logic [SIZE_W-1:0] SIZE_BYTE  = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_HALF  = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_WORD  = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_DWORD = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_room;
  } status_t;

endpackage

[src/armu_ctrl.sv]
// controller state machine: clearing pass, request accept, execute handoff
module armu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  armu_pkg::status_t status,
  output armu_pkg::cmd_t   cmd,
  output logic             in_stall
);
  import armu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (status.out_room) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = status.out_room;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[src/armu_dp.sv]
// datapath: word memory, request registers, lane extract, alu, merge and output register
module armu_dp #(
  parameter int STORE_WORDS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  armu_pkg::cmd_t               cmd,
  output armu_pkg::status_t            status,
  input  logic [armu_pkg::REQ_W-1:0]   in_req_type,
  input  logic [armu_pkg::SIZE_W-1:0]  in_size_code,
  input  logic [armu_pkg::ADDR_W-1:0]  in_byte_address,
  input  logic [armu_pkg::DATA_W-1:0]  in_operand,
  input  logic [armu_pkg::DATA_W-1:0]  in_expected_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [armu_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_success,
  output logic                         out_misaligned
);
  import armu_pkg::*;

  localparam int IW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int WA_W = ADDR_W - 3;
  localparam int WA_N = 1 << WA_W;

  // word address folded onto the store depth, worked out at elaboration
  logic [IW-1:0] idx_tab [WA_N];
  for (genvar i = 0; i < WA_N; i++) begin : g_idx
    assign idx_tab[i] = IW'(i % STORE_WORDS);
  end

  logic [DATA_W-1:0] mem [STORE_WORDS];
  logic [DATA_W-1:0] rdata_r;

  logic [IW-1:0]       clr_cnt_r;
  logic [IW-1:0]       idx_r;
  logic [REQ_W-1:0]    req_r;
  logic [SIZE_W-1:0]   size_r;
  logic [2:0]          lane_r;
  logic [DATA_W-1:0]   opnd_r;
  logic [DATA_W-1:0]   expv_r;

  logic                out_valid_r;
  logic [DATA_W-1:0]   out_read_data_r;
  logic                out_success_r;
  logic                out_misaligned_r;

  logic [IW-1:0]       rd_idx;
  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  logic [DATA_W-1:0]   mem_wdata;

  logic [SIZE_W-1:0]   sc_eff;
  logic [DATA_W-1:0]   mask;
  logic                mis;
  logic                known;
  logic [5:0]          sh;
  logic [DATA_W-1:0]   old;
  logic [DATA_W-1:0]   opnd_m;
  logic [DATA_W-1:0]   alu;
  logic [DATA_W-1:0]   nw;
  logic                wr;
  logic [DATA_W-1:0]   rd;
  logic                succ;
  logic [DATA_W-1:0]   merged;

  assign rd_idx = idx_tab[in_byte_address[ADDR_W-1:3]];

  assign status.clear_last = (clr_cnt_r == IW'(STORE_WORDS - 1));
  assign status.out_room   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt_r <= clr_cnt_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r  <= rd_idx;
      req_r  <= in_req_type;
      size_r <= in_size_code;
      lane_r <= in_byte_address[2:0];
      opnd_r <= in_operand;
      expv_r <= in_expected_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.accept) begin
      rdata_r <= mem[rd_idx];
    end
  end

  always_comb begin
    known  = (req_r <= REQ_FLAG_CLEAR);
    sc_eff = (req_r >= REQ_FLAG_SET) ? SIZE_BYTE : size_r;
    unique case (sc_eff)
      SIZE_BYTE:  begin mask = 64'h0000_0000_0000_00FF; mis = 1'b0; end
      SIZE_HALF:  begin mask = 64'h0000_0000_0000_FFFF; mis = lane_r[0]; end
      SIZE_WORD:  begin mask = 64'h0000_0000_FFFF_FFFF; mis = |lane_r[1:0]; end
      SIZE_DWORD: begin mask = '1;                      mis = |lane_r; end
      default:    begin mask = '1;                      mis = 1'b0; end
    endcase
    sh     = {lane_r, 3'b000};
    old    = (rdata_r >> sh) & mask;
    opnd_m = opnd_r & mask;

    unique case (req_r)
      REQ_FETCH_ADD,  REQ_ADD_FETCH:  alu = old + opnd_m;
      REQ_FETCH_SUB,  REQ_SUB_FETCH:  alu = old - opnd_m;
      REQ_FETCH_AND,  REQ_AND_FETCH:  alu = old & opnd_m;
      REQ_FETCH_OR,   REQ_OR_FETCH:   alu = old | opnd_m;
      REQ_FETCH_XOR,  REQ_XOR_FETCH:  alu = old ^ opnd_m;
      REQ_FETCH_NAND, REQ_NAND_FETCH: alu = ~(old & opnd_m);
      default:                        alu = old;
    endcase

    nw   = old;
    wr   = 1'b0;
    rd   = '0;
    succ = 1'b0;
    unique case (req_r)
      REQ_LOAD: begin
        rd = old;
      end
      REQ_STORE: begin
        nw = opnd_m; wr = 1'b1;
      end
      REQ_XCHG: begin
        rd = old; nw = opnd_m; wr = 1'b1;
      end
      REQ_CAS: begin
        rd = old;
        if (old == (expv_r & mask)) begin
          nw = opnd_m; wr = 1'b1; succ = 1'b1;
        end
      end
      REQ_FETCH_ADD, REQ_FETCH_SUB, REQ_FETCH_AND,
      REQ_FETCH_OR, REQ_FETCH_XOR, REQ_FETCH_NAND: begin
        rd = old; nw = alu & mask; wr = 1'b1;
      end
      REQ_ADD_FETCH, REQ_SUB_FETCH, REQ_AND_FETCH,
      REQ_OR_FETCH, REQ_XOR_FETCH, REQ_NAND_FETCH: begin
        nw = alu & mask; rd = alu & mask; wr = 1'b1;
      end
      REQ_FLAG_SET: begin
        rd = old; succ = (old != '0); nw = 64'd1; wr = 1'b1;
      end
      REQ_FLAG_CLEAR: begin
        nw = '0; wr = 1'b1;
      end
      default: begin
        wr = 1'b0;
      end
    endcase

    // misaligned or unknown requests leave memory alone and return zeros
    if (mis || !known) begin
      wr   = 1'b0;
      rd   = '0;
      succ = 1'b0;
    end

    merged = (rdata_r & ~(mask << sh)) | ((nw & mask) << sh);
  end

  always_comb begin
    if (cmd.clear_en) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = cmd.exec && wr;
      mem_waddr = idx_r;
      mem_wdata = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_read_data_r  <= rd;
      out_success_r    <= succ;
      out_misaligned_r <= mis && known;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_success    = out_success_r;
  assign out_misaligned = out_misaligned_r;

endmodule

[src/atomic_rmw_memory_unit.sv]
// top level of the atomic read-modify-write memory unit
// usage:
//   requests enter on the in_ channel (valid/stall); a beat is taken when
//   in_valid is high and in_stall is low. each request gives exactly one
//   result beat on the out_ channel, in request order.
//   a request is taken in the idle state (memory read issued) and executed
//   in the execute state (lane extract, alu, merge, write back, result
//   registered on out_valid) once the output register has room.
//   each request makes a single memory read-then-write sequence; no new
//   request is taken until the previous one has written back.
//   after reset the store is swept to zero one word per cycle; in_stall
//   stays high during the sweep.
//   when out_stall holds a result, the output register keeps it and the
//   next request may still be taken and read; it waits in execute until
//   the output register frees up.
module atomic_rmw_memory_unit #(
  parameter int STORE_WORDS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [armu_pkg::REQ_W-1:0]   in_req_type,
  input  logic [armu_pkg::SIZE_W-1:0]  in_size_code,
  input  logic [armu_pkg::ADDR_W-1:0]  in_byte_address,
  input  logic [armu_pkg::DATA_W-1:0]  in_operand,
  input  logic [armu_pkg::DATA_W-1:0]  in_expected_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [armu_pkg::DATA_W-1:0]  out_read_data,
  output logic                         out_success,
  output logic                         out_misaligned
);
  import armu_pkg::*;

  cmd_t    cmd;
  status_t status;

  armu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  armu_dp #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_req_type       (in_req_type),
    .in_size_code      (in_size_code),
    .in_byte_address   (in_byte_address),
    .in_operand        (in_operand),
    .in_expected_value (in_expected_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_success       (out_success),
    .out_misaligned    (out_misaligned)
  );

endmodule
